// ----- src/qpht_pkg.sv -----
// ---------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants of the quadratic probe hash table.
// ---------------------------------------------------------------------------
package qpht_pkg;

  // Table depth is a power of two so that the probe index wraps in SLOT_W bits.
  localparam int SLOT_W     = 7;
  localparam int TABLE_SIZE = 1 << SLOT_W;

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_OUT_W = 7;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [VAL_W-1:0]  val_t;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PROBE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic  start;
    logic  advance;
    slot_t start_idx;
  } probe_ctrl_t;

  typedef struct packed {
    logic  en;
    slot_t addr;
    key_t  key;
    val_t  value;
  } store_wr_t;

endpackage

// ----- src/qpht_probe.sv -----
// ---------------------------------------------------------------------------
// qpht_probe
// Probe index walker: steps idx by 1, 3, 5, ... mod size.
// ---------------------------------------------------------------------------
module qpht_probe (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qpht_pkg::probe_ctrl_t ctrl_i,
  output qpht_pkg::slot_t      idx_o,
  output qpht_pkg::slot_t      rd_addr_o,
  output logic                 last_o
);

  qpht_pkg::slot_t idx_q, idx_d;
  qpht_pkg::slot_t step_q, step_d;
  qpht_pkg::slot_t cnt_q, cnt_d;
  qpht_pkg::slot_t next_idx;

  // i*i - (i-1)*(i-1) = 2i-1, so the sequence is a running sum of odd steps
  assign next_idx = idx_q + step_q;

  always_comb begin
    idx_d  = idx_q;
    step_d = step_q;
    cnt_d  = cnt_q;
    if (ctrl_i.start) begin
      idx_d  = ctrl_i.start_idx;
      step_d = qpht_pkg::SLOT_W'(1);
      cnt_d  = '0;
    end else if (ctrl_i.advance) begin
      idx_d  = next_idx;
      step_d = step_q + qpht_pkg::SLOT_W'(2);
      cnt_d  = cnt_q + qpht_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      idx_q  <= idx_d;
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

  assign idx_o     = idx_q;
  assign rd_addr_o = ctrl_i.advance ? next_idx : idx_q;
  assign last_o    = (cnt_q == qpht_pkg::SLOT_W'(qpht_pkg::TABLE_SIZE - 1));

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> (cnt_q == '0) && (step_q == qpht_pkg::SLOT_W'(1)))
    else $error("probe start did not reset count and step");

  a_advance_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.advance && !ctrl_i.start) |=>
      (cnt_q == $past(cnt_q) + qpht_pkg::SLOT_W'(1)) && (idx_q == $past(next_idx)))
    else $error("probe advance did not step index and count");

  a_odd_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctrl_i.start) |-> step_q[0])
    else $error("probe step lost its odd phase");

endmodule

// ----- src/qpht_store.sv -----
// ---------------------------------------------------------------------------
// qpht_store
// Slot storage: key and value memory with registered read, valid flops.
// ---------------------------------------------------------------------------
module qpht_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qpht_pkg::slot_t     rd_addr_i,
  input  qpht_pkg::slot_t     chk_idx_i,
  input  qpht_pkg::store_wr_t wr_i,
  output qpht_pkg::key_t      rd_key_o,
  output qpht_pkg::val_t      rd_val_o,
  output logic                slot_vld_o
);

  qpht_pkg::key_t key_mem [qpht_pkg::TABLE_SIZE];
  qpht_pkg::val_t val_mem [qpht_pkg::TABLE_SIZE];
  logic [qpht_pkg::TABLE_SIZE-1:0] valid_q;
  qpht_pkg::key_t rd_key_q;
  qpht_pkg::val_t rd_val_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      key_mem[wr_i.addr] <= wr_i.key;
      val_mem[wr_i.addr] <= wr_i.value;
    end
    rd_key_q <= key_mem[rd_addr_i];
    rd_val_q <= val_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_val_o   = rd_val_q;
  assign slot_vld_o = valid_q[chk_idx_i];

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.en |=> valid_q[$past(wr_i.addr)])
    else $error("slot write did not set its valid bit");

  a_valid_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_i.en |=> valid_q == $past(valid_q))
    else $error("valid bits changed without a write");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $countones($past(valid_q)))
    else $error("occupied slot count dropped");

endmodule

// ----- src/quadratic_probe_hash_table.sv -----
// ---------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table with quadratic probing, insert and lookup.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Fields (tdata from bit 0 up)                  tuser
// s_*      in   key_id[31:0] key_hash[63:32] value_in[79:64]  req_type
// m_*      out  status[1:0] value_out[17:2] slot[24:18]       -
//
// Steps: a request walks k probes, k = probes walked (1 .. TABLE_SIZE):
//   accept, first memory read, one probe per cycle, result hand-off.
//   The probe rate is set by the single registered read port of the slot memory.
// Reset: valid bits clear at once; no clearing pass. Key/value memory is not reset.
// Stalls: a new request is taken while a result waits on m_*; its result
//   holds in the hand-off state until the output register frees up.
//
module quadratic_probe_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [79:0] s_tdata_i,   // key_id[31:0], key_hash[63:32], value_in[79:64]
  input  logic        s_tuser_i,   // req_type
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o    // status[1:0], value_out[17:2], slot[24:18], zero
);

  qpht_pkg::state_e state_q, state_d;

  // latched request
  logic           req_q;
  qpht_pkg::key_t key_q;
  qpht_pkg::val_t val_q;

  // resolved result, waiting for the output register
  logic [qpht_pkg::STATUS_W-1:0] res_sts_q, res_sts_d;
  qpht_pkg::val_t                res_val_q, res_val_d;
  qpht_pkg::slot_t               res_slot_q, res_slot_d;

  // output register
  logic        out_vld_q;
  logic [31:0] out_data_q;

  qpht_pkg::probe_ctrl_t probe_ctrl;
  qpht_pkg::store_wr_t   wr;
  qpht_pkg::slot_t       idx, rd_addr;
  logic                  last;
  qpht_pkg::key_t        rd_key;
  qpht_pkg::val_t        rd_val;
  logic                  slot_vld;

  logic s_acc, out_free, empty, match, resolved, load_out;
  logic [31:0] slot_ext;

  assign s_acc    = s_tvalid_i && s_tready_o;
  assign out_free = !out_vld_q || m_tready_i;

  // probe outcome for the slot whose data sits in the read register
  assign empty    = !slot_vld;
  assign match    = slot_vld && (rd_key == key_q);
  assign resolved = empty || match || last;

  qpht_probe u_probe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (probe_ctrl),
    .idx_o     (idx),
    .rd_addr_o (rd_addr),
    .last_o    (last)
  );

  qpht_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (rd_addr),
    .chk_idx_i  (idx),
    .wr_i       (wr),
    .rd_key_o   (rd_key),
    .rd_val_o   (rd_val),
    .slot_vld_o (slot_vld)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qpht_pkg::S_IDLE:  if (s_acc) state_d = qpht_pkg::S_READ;
      qpht_pkg::S_READ:  state_d = qpht_pkg::S_PROBE;
      qpht_pkg::S_PROBE: if (resolved) state_d = qpht_pkg::S_RESP;
      qpht_pkg::S_RESP:  if (out_free) state_d = qpht_pkg::S_IDLE;
      default:           state_d = qpht_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready_o           = 1'b0;
    probe_ctrl.start     = 1'b0;
    probe_ctrl.advance   = 1'b0;
    probe_ctrl.start_idx = s_tdata_i[32 +: qpht_pkg::SLOT_W];  // hash mod size
    wr.en                = 1'b0;
    wr.addr              = idx;
    wr.key               = key_q;
    wr.value             = val_q;
    load_out             = 1'b0;
    res_sts_d            = res_sts_q;
    res_val_d            = res_val_q;
    res_slot_d           = res_slot_q;
    unique case (state_q)
      qpht_pkg::S_IDLE: begin
        s_tready_o       = 1'b1;
        probe_ctrl.start = s_acc;
      end
      qpht_pkg::S_READ: begin
        // rd_addr is the start slot; data shows up next cycle
      end
      qpht_pkg::S_PROBE: begin
        probe_ctrl.advance = !resolved;
        res_val_d          = '0;
        res_slot_d         = '0;
        if (req_q == qpht_pkg::REQ_INSERT) begin
          if (empty || match) begin
            wr.en      = 1'b1;
            res_sts_d  = qpht_pkg::STS_OK;
            res_slot_d = idx;
          end else begin
            res_sts_d  = qpht_pkg::STS_FULL;
          end
        end else begin
          if (match) begin
            res_sts_d  = qpht_pkg::STS_OK;
            res_val_d  = rd_val;
            res_slot_d = idx;
          end else begin
            res_sts_d  = qpht_pkg::STS_NOT_FOUND;
          end
        end
      end
      qpht_pkg::S_RESP: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  assign slot_ext = {{(32 - qpht_pkg::SLOT_W){1'b0}}, res_slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= qpht_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      req_q <= s_tuser_i;
      key_q <= s_tdata_i[31:0];
      val_q <= s_tdata_i[79:64];
    end
    res_sts_q  <= res_sts_d;
    res_val_q  <= res_val_d;
    res_slot_q <= res_slot_d;
    if (load_out) begin
      out_data_q <= {7'd0, slot_ext[qpht_pkg::SLOT_OUT_W-1:0], res_val_q, res_sts_q};
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

  a_write_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == qpht_pkg::S_PROBE) && (req_q == qpht_pkg::REQ_INSERT))
    else $error("slot write outside an insert probe");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_tready_o)
    else $error("request taken while previous one still probing");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == qpht_pkg::S_RESP) && out_free)
    else $error("result loaded over an unconsumed one");

  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && (m_tdata_o[1:0] != qpht_pkg::STS_OK)) |-> (m_tdata_o[24:2] == '0))
    else $error("failed request carries nonzero value or slot");

endmodule

// ----- dv/qpht_reply_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpht_reply_checker
// Watches the request and reply channels of the hash table, keeps its own
// copy of the slot contents, predicts every reply and compares it on arrival.
// ---------------------------------------------------------------------------
module qpht_reply_checker
  import qpht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [79:0] s_tdata_i,   // key_id[31:0], key_hash[63:32], value_in[79:64]
  input  logic        s_tuser_i,   // req_type
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [31:0] m_tdata_i,   // status[1:0], value_out[17:2], slot[24:18], zero
  output int          fail_cnt_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    val_t                  value;
    logic [SLOT_OUT_W-1:0] slot;
  } outcome_t;

  // Shadow of the table
  bit   slot_used [TABLE_SIZE];
  key_t slot_key  [TABLE_SIZE];
  val_t slot_val  [TABLE_SIZE];

  outcome_t outcome_q[$];
  int       mismatches = 0;
  int       replies_seen = 0;

  assign fail_cnt_o = mismatches;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h (reply %0d)",
             $time, what, got, want, replies_seen);
  endtask

  // Walks the quadratic probe run and applies the request to the shadow table.
  function automatic outcome_t table_access(logic kind, key_t key, key_t hash, val_t value);
    outcome_t res;
    slot_t    idx;
    slot_t    stop_idx;
    bit       stopped;
    bit       hit;
    res.status = STS_OK;
    res.value  = '0;
    res.slot   = '0;
    stopped    = 1'b0;
    hit        = 1'b0;
    stop_idx   = '0;
    for (int i = 0; i < TABLE_SIZE && !stopped; i++) begin
      // power-of-two depth: the sum wraps in SLOT_W bits
      idx = hash[SLOT_W-1:0] + slot_t'(i * i);
      if (!slot_used[idx]) begin
        stopped  = 1'b1;
        stop_idx = idx;
      end else if (slot_key[idx] == key) begin
        stopped  = 1'b1;
        hit      = 1'b1;
        stop_idx = idx;
      end
    end
    if (kind == REQ_INSERT) begin
      if (stopped) begin
        slot_used[stop_idx] = 1'b1;
        slot_key[stop_idx]  = key;
        slot_val[stop_idx]  = value;
        res.slot            = stop_idx;
      end else begin
        res.status = STS_FULL;
      end
    end else begin
      if (stopped && hit) begin
        res.value = slot_val[stop_idx];
        res.slot  = stop_idx;
      end else begin
        res.status = STS_NOT_FOUND;
      end
    end
    return res;
  endfunction

  task automatic check_reply(logic [31:0] word);
    outcome_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch("reply with no request outstanding", word, 32'h0);
    end else begin
      want = outcome_q.pop_front();
      if (word[1:0] != want.status)
        report_mismatch("status", 32'(word[1:0]), 32'(want.status));
      if (word[17:2] != want.value)
        report_mismatch("value_out", 32'(word[17:2]), 32'(want.value));
      if (word[24:18] != want.slot)
        report_mismatch("slot", 32'(word[24:18]), 32'(want.slot));
      if (word[31:25] != '0)
        report_mismatch("padding bits", 32'(word[31:25]), 32'h0);
    end
    replies_seen++;
  endtask

  // Reply first: a reply and a new request can share an edge, and the reply
  // always belongs to an older request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < TABLE_SIZE; n++) slot_used[n] = 1'b0;
      outcome_q.delete();
      outstanding_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_reply(m_tdata_i);
      if (s_tvalid_i && s_tready_i) begin
        outcome_q.push_back(table_access(s_tuser_i, s_tdata_i[31:0],
                                         s_tdata_i[63:32], s_tdata_i[79:64]));
      end
      outstanding_o <= outcome_q.size();
    end
  end

endmodule

// ----- dv/tb_quadratic_probe_hash_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_quadratic_probe_hash_table
// Drives insert and lookup requests into the hash table and gives the verdict;
// qpht_reply_checker predicts and compares every reply beside the block.
// ---------------------------------------------------------------------------
module tb_quadratic_probe_hash_table;
  import qpht_pkg::*;

  localparam int NUM_RANDOM      = 880;
  localparam int POOL_SIZE       = 128;
  localparam int GROUP_SIZE      = 32;    // keys sharing one probe start
  localparam int HOLD_OFF_AFTER  = 40;    // requests sent before the long stall
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 140;   // wait for stray replies after the last one
  localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any handshake

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [79:0] s_tdata_i;   // key_id[31:0], key_hash[63:32], value_in[79:64]
  logic        s_tuser_i;   // req_type
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [31:0] m_tdata_o;   // status[1:0], value_out[17:2], slot[24:18], zero

  int fail_cnt;
  int outstanding;

  // Traffic shaping, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_cnt       = 0;

  // Keys with a fixed probe start, grouped so that each group crowds the
  // same ~23 reachable slots; groups are larger than that, so the crowded
  // probe runs end up exhausted (full on insert, miss on lookup).
  key_t  pool_key  [POOL_SIZE];
  slot_t pool_base [POOL_SIZE];

  quadratic_probe_hash_table u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  qpht_reply_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid_i),
    .s_tready_i    (s_tready_o),
    .s_tdata_i     (s_tdata_i),
    .s_tuser_i     (s_tuser_i),
    .m_tvalid_i    (m_tvalid_o),
    .m_tready_i    (m_tready_i),
    .m_tdata_i     (m_tdata_o),
    .fail_cnt_o    (fail_cnt),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offers one request, with random idle cycles ahead of it, and returns at
  // the edge where it is taken. tvalid stays up into the next request.
  task automatic send_request(logic kind, key_t key, key_t hash, val_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= kind;
    s_tdata_i  <= {value, hash, key};
    do @(posedge clk_i); while (!s_tready_o);
    sent_cnt++;
  endtask

  // Mostly pool traffic (real probe chains), some stray keys and wrong hashes.
  task automatic send_random();
    int   pick;
    int   sel;
    logic kind;
    key_t key;
    key_t hash;
    val_t value;
    pick  = $urandom_range(99);
    sel   = $urandom_range(POOL_SIZE - 1);
    key   = pool_key[sel];
    hash  = $urandom();
    hash[SLOT_W-1:0] = pool_base[sel];    // upper hash bits do not steer the probe
    value = val_t'($urandom());
    kind  = (pick < 48) ? REQ_INSERT : REQ_LOOKUP;
    if ((pick >= 44 && pick < 48) || pick >= 94) begin
      key  = $urandom();                  // stray key, anywhere in the table
      hash = $urandom();
    end else if (pick >= 88) begin
      hash = $urandom();                  // known key looked up from the wrong start
    end
    send_request(kind, key, hash, value);
  endtask

  // Result side: random stalls, plus one long hold-off early on while the
  // sender keeps pushing, so the block backs up into its input.
  initial begin : result_sink
    bit held;
    held       = 1'b0;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent_cnt >= HOLD_OFF_AFTER) begin
        held = 1'b1;
        m_tready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends a hung run: counts cycles with no handshake on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tuser_i  = REQ_INSERT;
    s_tdata_i  = '0;

    for (int n = 0; n < POOL_SIZE; n++) begin
      pool_key[n] = $urandom();
      case (n / GROUP_SIZE)
        0:       pool_base[n] = 7'h00;
        1:       pool_base[n] = 7'h7f;
        2:       pool_base[n] = 7'h2a;
        default: pool_base[n] = 7'h55;
      endcase
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part, no idling ---
    // lookup on the empty table stops at the first empty slot
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'hffff);
    // all-ones fields, top slot
    send_request(REQ_INSERT, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
    send_request(REQ_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 16'h0000);
    // all-zero fields, slot 0
    send_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    // same probe start: collisions walk to slots 1, 4, 9
    send_request(REQ_INSERT, 32'h0000_0001, 32'h0000_0080, 16'h1234);
    send_request(REQ_INSERT, 32'h0000_0002, 32'h0000_0100, 16'h5678);
    send_request(REQ_INSERT, 32'h0000_0003, 32'h0000_0000, 16'h9abc);
    // overwrite of an existing key in place
    send_request(REQ_INSERT, 32'h0000_0001, 32'h0000_0000, 16'habcd);
    send_request(REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 16'h0000);
    send_request(REQ_LOOKUP, 32'h0000_0003, 32'h8000_0000, 16'h5555);
    // miss after walking an occupied chain
    send_request(REQ_LOOKUP, 32'h0000_0004, 32'h0000_0000, 16'h0000);
    // known key from a different start: miss
    send_request(REQ_LOOKUP, 32'h0000_0003, 32'h0000_0005, 16'h0000);
    // probe index wraps past the top slot (127, 0, then 3)
    send_request(REQ_INSERT, 32'h8000_0000, 32'h0000_007f, 16'h8000);
    send_request(REQ_LOOKUP, 32'h8000_0000, 32'hffff_ff7f, 16'h0000);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'hffff);
    send_request(REQ_INSERT, 32'hffff_ffff, 32'h0000_007f, 16'h0000);
    send_request(REQ_LOOKUP, 32'hffff_ffff, 32'h0000_007f, 16'h0000);

    // --- random part, four traffic phases ---
    for (int n = 0; n < NUM_RANDOM; n++) begin
      case (n * 4 / NUM_RANDOM)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      send_random();
    end

    // Drain: wait for every reply, then give stray replies time to show up.
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
